/* rtl/tkca_pkg.sv */
package tkca_pkg;

  localparam int TRACKED_DEF = 8;
  localparam int MAX_RESULTS = 8;

  localparam int AREA_W  = 24;
  localparam int WHITE_W = 23;
  localparam int INDEX_W = 16;
  localparam int RANK_W  = 4;
  localparam int SLOT_W  = 3;

  localparam logic [WHITE_W-1:0] HOLE_RESET = WHITE_W'(40);
  localparam logic [WHITE_W-1:0] WHITE_SAT  = WHITE_W'(4194304);

  typedef enum logic {
    KIND_CONTOUR = 1'b0,
    KIND_EOF     = 1'b1
  } kind_t;

  typedef struct packed {
    logic ins_en;
    logic shift_en;
    logic clr_en;
  } list_ctrl_t;

endpackage

/* rtl/tkca_eval.sv */
module tkca_eval import tkca_pkg::*; (
  input  logic signed [AREA_W-1:0]  area,
  input  logic        [WHITE_W-1:0] hole_limit,
  output logic        [WHITE_W-1:0] white,
  output logic                      is_hole
);

  logic signed [AREA_W:0] area_x;
  logic signed [AREA_W:0] limit_x;
  logic signed [AREA_W:0] neg_x;

  always_comb begin
    area_x  = {area[AREA_W-1], area};
    limit_x = {{(AREA_W-WHITE_W+1){1'b0}}, hole_limit};
    neg_x   = -area_x;
    is_hole = area_x > limit_x;
    // white area, saturated; non-white contours get zero and are never kept
    if (area_x >= 0) begin
      white = '0;
    end else if (neg_x > $signed({{(AREA_W-WHITE_W+1){1'b0}}, WHITE_SAT})) begin
      white = WHITE_SAT;
    end else begin
      white = neg_x[WHITE_W-1:0];
    end
  end

endmodule

/* rtl/tkca_list.sv */
module tkca_list import tkca_pkg::*; #(
  parameter int TRACKED = TRACKED_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  list_ctrl_t         ctrl,
  input  logic [WHITE_W-1:0] white,
  input  logic [INDEX_W-1:0] index,
  output logic [RANK_W-1:0]  rank,
  output logic [WHITE_W-1:0] head_area,
  output logic [INDEX_W-1:0] head_index
);

  logic [WHITE_W-1:0] areas_r     [TRACKED];
  logic [WHITE_W-1:0] areas_nxt   [TRACKED];
  logic [INDEX_W-1:0] indices_r   [TRACKED];
  logic [INDEX_W-1:0] indices_nxt [TRACKED];

  logic [TRACKED-1:0] lt;
  logic [TRACKED:0]   lt_prev;
  logic [TRACKED-1:0] first;
  logic [RANK_W-1:0]  rank_or;

  // list is descending, so lt is a thermometer code; first marks the entry slot
  always_comb begin
    for (int j = 0; j < TRACKED; j++) begin
      lt[j] = areas_r[j] < white;
    end
    lt_prev = {lt, 1'b0};
    first   = lt & ~lt_prev[TRACKED-1:0];
    rank_or = '0;
    for (int j = 0; j < TRACKED; j++) begin
      if (first[j]) begin
        rank_or = rank_or | RANK_W'(j);
      end
    end
    rank = (|lt) ? rank_or : RANK_W'(TRACKED);
  end

  always_comb begin
    for (int j = 0; j < TRACKED; j++) begin
      areas_nxt[j]   = areas_r[j];
      indices_nxt[j] = indices_r[j];
    end
    if (ctrl.clr_en) begin
      for (int j = 0; j < TRACKED; j++) begin
        areas_nxt[j]   = '0;
        indices_nxt[j] = '0;
      end
    end else if (ctrl.shift_en) begin
      for (int j = 0; j < TRACKED - 1; j++) begin
        areas_nxt[j]   = areas_r[j+1];
        indices_nxt[j] = indices_r[j+1];
      end
      areas_nxt[TRACKED-1]   = '0;
      indices_nxt[TRACKED-1] = '0;
    end else if (ctrl.ins_en) begin
      if (first[0]) begin
        areas_nxt[0]   = white;
        indices_nxt[0] = index;
      end
      for (int j = 1; j < TRACKED; j++) begin
        if (first[j]) begin
          areas_nxt[j]   = white;
          indices_nxt[j] = index;
        end else if (lt[j]) begin
          areas_nxt[j]   = areas_r[j-1];
          indices_nxt[j] = indices_r[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < TRACKED; j++) begin
        areas_r[j]   <= '0;
        indices_r[j] <= '0;
      end
    end else begin
      for (int j = 0; j < TRACKED; j++) begin
        areas_r[j]   <= areas_nxt[j];
        indices_r[j] <= indices_nxt[j];
      end
    end
  end

  assign head_area  = areas_r[0];
  assign head_index = indices_r[0];

endmodule

/* rtl/top_k_contour_area_tracker.sv */
// Top-K contour area tracker.
// Input channel (in_valid / in_stall): one request per contour or per end of
// frame. A contour request returns one verdict: hole flag and the rank at
// which its white area entered the descending list (TRACKED = not kept).
// An end-of-frame request returns min(TRACKED, 8) slot results, largest
// first, the last one flagged by out_last_of_run, and leaves the list empty.
// Output channel (out_valid / out_stall): out_stall holds the result register;
// the request register in front of it keeps taking one request while a
// result waits.
// Throughput: one contour per cycle while out_stall is low; an end of frame
// occupies the list for its whole readout, one slot read out per cycle while
// out_stall is low, by shifting the list. All slots are compared in parallel
// against the new area combinationally. The user writes hole_area_limit
// via cfg_wr_en / cfg_wr_data only while idle; the block does not enforce it.
// Synchronous reset (rst_n low) empties the list, drops any request or
// result in flight and sets hole_area_limit to 40.
module top_k_contour_area_tracker import tkca_pkg::*; #(
  parameter int TRACKED = TRACKED_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic        [WHITE_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic signed [AREA_W-1:0]  in_contour_area,
  input  logic        [INDEX_W-1:0] in_contour_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_entry_kind,
  output logic                      out_is_hole,
  output logic        [RANK_W-1:0]  out_insert_rank,
  output logic        [SLOT_W-1:0]  out_slot_rank,
  output logic        [WHITE_W-1:0] out_slot_area,
  output logic        [INDEX_W-1:0] out_slot_index,
  output logic                      out_last_of_run
);

  localparam int NREAD = (TRACKED < MAX_RESULTS) ? TRACKED : MAX_RESULTS;

  logic [WHITE_W-1:0] hole_limit_r;

  logic                     in_v_r, in_v_nxt;
  kind_t                    in_kind_r;
  logic signed [AREA_W-1:0] in_area_r;
  logic [INDEX_W-1:0]       in_index_r;

  logic [SLOT_W-1:0] rd_cnt_r, rd_cnt_nxt;

  logic               out_v_r, out_v_nxt;
  kind_t              out_kind_r;
  logic               out_hole_r;
  logic [RANK_W-1:0]  out_rank_r;
  logic [SLOT_W-1:0]  out_slot_rank_r;
  logic [WHITE_W-1:0] out_area_r;
  logic [INDEX_W-1:0] out_index_r;
  logic               out_last_r;

  logic               out_free, fire, is_eof, rd_last, consume, in_take;
  list_ctrl_t         ctrl;
  logic [WHITE_W-1:0] white;
  logic               is_hole;
  logic [RANK_W-1:0]  rank;
  logic [WHITE_W-1:0] head_area;
  logic [INDEX_W-1:0] head_index;

  tkca_eval u_eval (
    .area       (in_area_r),
    .hole_limit (hole_limit_r),
    .white      (white),
    .is_hole    (is_hole)
  );

  tkca_list #(.TRACKED(TRACKED)) u_list (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .white      (white),
    .index      (in_index_r),
    .rank       (rank),
    .head_area  (head_area),
    .head_index (head_index)
  );

  always_comb begin
    out_free      = !out_v_r || !out_stall;
    fire          = in_v_r && out_free;
    is_eof        = in_kind_r == KIND_EOF;
    rd_last       = rd_cnt_r == SLOT_W'(NREAD - 1);
    consume       = fire && (!is_eof || rd_last);
    in_stall      = in_v_r && !consume;
    in_take       = in_valid && !in_stall;
    ctrl.ins_en   = fire && !is_eof;
    ctrl.shift_en = fire && is_eof && !rd_last;
    ctrl.clr_en   = fire && is_eof && rd_last;

    in_v_nxt = in_take ? 1'b1 : (consume ? 1'b0 : in_v_r);

    rd_cnt_nxt = rd_cnt_r;
    if (fire && is_eof) begin
      rd_cnt_nxt = rd_last ? '0 : rd_cnt_r + SLOT_W'(1);
    end

    out_v_nxt = fire ? 1'b1 : (out_stall ? out_v_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hole_limit_r <= HOLE_RESET;
      in_v_r       <= 1'b0;
      rd_cnt_r     <= '0;
      out_v_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        hole_limit_r <= cfg_wr_data;
      end
      in_v_r   <= in_v_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_kind_r  <= kind_t'(in_kind);
      in_area_r  <= in_contour_area;
      in_index_r <= in_contour_index;
    end
    if (fire) begin
      if (is_eof) begin
        out_kind_r      <= KIND_EOF;
        out_hole_r      <= 1'b0;
        out_rank_r      <= '0;
        out_slot_rank_r <= rd_cnt_r;
        out_area_r      <= head_area;
        out_index_r     <= head_index;
        out_last_r      <= rd_last;
      end else begin
        out_kind_r      <= KIND_CONTOUR;
        out_hole_r      <= is_hole;
        out_rank_r      <= rank;
        out_slot_rank_r <= '0;
        out_area_r      <= '0;
        out_index_r     <= '0;
        out_last_r      <= 1'b1;
      end
    end
  end

  assign out_valid       = out_v_r;
  assign out_entry_kind  = out_kind_r;
  assign out_is_hole     = out_hole_r;
  assign out_insert_rank = out_rank_r;
  assign out_slot_rank   = out_slot_rank_r;
  assign out_slot_area   = out_area_r;
  assign out_slot_index  = out_index_r;
  assign out_last_of_run = out_last_r;

  a_rd_only_in_eof: assert property (@(posedge clk) disable iff (!rst_n)
    rd_cnt_r != '0 |-> (in_v_r && in_kind_r == KIND_EOF))
    else $error("readout counter moved outside end of frame");

  a_list_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clr_en |=> (head_area == '0 && head_index == '0))
    else $error("list not empty after end-of-frame readout");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall) |=> (out_v_r && $stable(out_area_r) && $stable(out_rank_r)))
    else $error("stalled result register changed");

  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_kind_r == KIND_CONTOUR) |-> out_last_r)
    else $error("contour verdict without end-of-run flag");

endmodule
